FILE: src/cps_pkg.sv
package cps_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_DIV,
        OP_ADD,
        OP_SUB,
        OP_TRIG,
        OP_END
    } alu_op_t;

    typedef enum logic [4:0] {
        SRC_PM,
        SRC_HPL,
        SRC_TM,
        SRC_G,
        SRC_TS,
        SRC_K43,
        SRC_FORCE,
        SRC_POS,
        SRC_VEL,
        SRC_ANG,
        SRC_RATE,
        SRC_S,
        SRC_C,
        SRC_PML,
        SRC_T1,
        SRC_T2,
        SRC_TEMP,
        SRC_NUM,
        SRC_DEN,
        SRC_TACC,
        SRC_XACC
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_PML,
        DST_T1,
        DST_T2,
        DST_TEMP,
        DST_DEN,
        DST_NUM,
        DST_TACC,
        DST_XACC,
        DST_POS,
        DST_VEL,
        DST_ANG,
        DST_RATE
    } dst_t;

    typedef struct packed {
        alu_op_t op;
        src_t    a;
        src_t    b;
        dst_t    dst;
    } uop_t;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_MUL,
        AS_DIV,
        AS_FIN
    } alu_state_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_MOD,
        TS_WRAP,
        TS_HALF,
        TS_ROT,
        TS_FIN
    } trig_state_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_FORCE = 3'd0;
    localparam logic [2:0] REG_TSTEP = 3'd1;
    localparam logic [2:0] REG_GRAV  = 3'd2;
    localparam logic [2:0] REG_PMASS = 3'd3;
    localparam logic [2:0] REG_TMASS = 3'd4;
    localparam logic [2:0] REG_HALFL = 3'd5;

    localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
    localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
    localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
    localparam logic signed [63:0] Q30_GAIN    = 64'sd652032874;

    localparam logic [63:0] Q32_FOUR_THIRDS = 64'd5726623061;
    localparam logic [63:0] Q32_X_LIMIT     = 64'd10307921510;
    localparam logic [63:0] Q32_X_EDGE      = 64'd3435973837;
    localparam logic [63:0] Q32_V_EDGE      = 64'd2147483648;
    localparam logic [63:0] Q32_DEG12       = 64'd899531079;
    localparam logic [63:0] Q32_DEG6        = 64'd449765539;
    localparam logic [63:0] Q32_DEG1        = 64'd74960923;
    localparam logic [63:0] Q32_DEG50       = 64'd3748046161;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = SAT_MAX;
        end
        else if (v < -64'sh0000_0000_8000_0000) begin
            r = SAT_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd843314856;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043836;
            5'd3:  r = 32'd133525158;
            5'd4:  r = 32'd67021686;
            5'd5:  r = 32'd33543515;
            5'd6:  r = 32'd16775850;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194282;
            5'd9:  r = 32'd2097149;
            5'd10: r = 32'd1048575;
            5'd11: r = 32'd524287;
            5'd12: r = 32'd262143;
            5'd13: r = 32'd131071;
            5'd14: r = 32'd65535;
            5'd15: r = 32'd32767;
            5'd16: r = 32'd16383;
            5'd17: r = 32'd8191;
            5'd18: r = 32'd4095;
            5'd19: r = 32'd2047;
            5'd20: r = 32'd1023;
            5'd21: r = 32'd511;
            5'd22: r = 32'd255;
            5'd23: r = 32'd127;
            5'd24: r = 32'd63;
            5'd25: r = 32'd31;
            5'd26: r = 32'd15;
            5'd27: r = 32'd8;
            5'd28: r = 32'd4;
            5'd29: r = 32'd2;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // step program: trig first, then the dynamics, then the Euler update
    function automatic uop_t uop_at(input logic [4:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = '{OP_TRIG, SRC_ANG,   SRC_ANG,  DST_NONE};
            5'd1:  u = '{OP_MUL,  SRC_PM,    SRC_HPL,  DST_PML};
            5'd2:  u = '{OP_MUL,  SRC_RATE,  SRC_RATE, DST_T1};
            5'd3:  u = '{OP_MUL,  SRC_PML,   SRC_T1,   DST_T1};
            5'd4:  u = '{OP_MUL,  SRC_T1,    SRC_S,    DST_T1};
            5'd5:  u = '{OP_ADD,  SRC_FORCE, SRC_T1,   DST_T1};
            5'd6:  u = '{OP_DIV,  SRC_T1,    SRC_TM,   DST_TEMP};
            5'd7:  u = '{OP_MUL,  SRC_C,     SRC_C,    DST_T1};
            5'd8:  u = '{OP_MUL,  SRC_PM,    SRC_T1,   DST_T1};
            5'd9:  u = '{OP_DIV,  SRC_T1,    SRC_TM,   DST_T1};
            5'd10: u = '{OP_SUB,  SRC_K43,   SRC_T1,   DST_T1};
            5'd11: u = '{OP_MUL,  SRC_HPL,   SRC_T1,   DST_DEN};
            5'd12: u = '{OP_MUL,  SRC_G,     SRC_S,    DST_T1};
            5'd13: u = '{OP_MUL,  SRC_C,     SRC_TEMP, DST_T2};
            5'd14: u = '{OP_SUB,  SRC_T1,    SRC_T2,   DST_NUM};
            5'd15: u = '{OP_DIV,  SRC_NUM,   SRC_DEN,  DST_TACC};
            5'd16: u = '{OP_MUL,  SRC_PML,   SRC_TACC, DST_T1};
            5'd17: u = '{OP_MUL,  SRC_T1,    SRC_C,    DST_T1};
            5'd18: u = '{OP_DIV,  SRC_T1,    SRC_TM,   DST_T1};
            5'd19: u = '{OP_SUB,  SRC_TEMP,  SRC_T1,   DST_XACC};
            5'd20: u = '{OP_MUL,  SRC_TS,    SRC_VEL,  DST_T1};
            5'd21: u = '{OP_ADD,  SRC_POS,   SRC_T1,   DST_POS};
            5'd22: u = '{OP_MUL,  SRC_TS,    SRC_XACC, DST_T1};
            5'd23: u = '{OP_ADD,  SRC_VEL,   SRC_T1,   DST_VEL};
            5'd24: u = '{OP_MUL,  SRC_TS,    SRC_RATE, DST_T1};
            5'd25: u = '{OP_ADD,  SRC_ANG,   SRC_T1,   DST_ANG};
            5'd26: u = '{OP_MUL,  SRC_TS,    SRC_TACC, DST_T1};
            5'd27: u = '{OP_ADD,  SRC_RATE,  SRC_T1,   DST_RATE};
            default: u = '{OP_END, SRC_POS,  SRC_POS,  DST_NONE};
        endcase
        return u;
    endfunction

endpackage

FILE: src/cps_alu.sv
module cps_alu #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cps_pkg::alu_op_t     op,
    input  logic signed [31:0]   a,
    input  logic signed [31:0]   b,
    output logic                 done,
    output logic signed [31:0]   res
);
    import cps_pkg::*;

    alu_state_t state_reg, state_next;
    logic done_reg;
    logic signed [31:0] res_reg;
    logic signed [63:0] prod_reg;
    logic neg_reg;
    logic [31:0] dvs_reg, rem_reg, lo_reg, quo_reg;
    logic [5:0] cnt_reg;

    logic [31:0] mag_a, mag_b;
    logic [63:0] num_w;
    logic [32:0] rem_sh;
    logic ge;
    logic div_short;
    logic signed [63:0] rnd;
    logic signed [31:0] div_quick, div_fin;

    always_comb
    begin
        mag_a = a[31] ? 32'(-a) : 32'(a);
        mag_b = b[31] ? 32'(-b) : 32'(b);
        num_w = {32'd0, mag_a} << FRAC_BITS;
        div_short = (b == 32'sd0) || (num_w[63:32] >= mag_b);
        rem_sh = {rem_reg, lo_reg[31]};
        ge = rem_sh >= {1'b0, dvs_reg};
        rnd = (prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        // divisor zero or quotient past 32 bits: saturate by sign
        if (b == 32'sd0) begin
            div_quick = (a > 32'sd0) ? SAT_MAX : ((a < 32'sd0) ? SAT_MIN : 32'sd0);
        end
        else begin
            div_quick = (a[31] ^ b[31]) ? SAT_MIN : SAT_MAX;
        end
        if (neg_reg) begin
            div_fin = (quo_reg > 32'h8000_0000) ? SAT_MIN : 32'(-quo_reg);
        end
        else begin
            div_fin = (quo_reg > 32'h7FFF_FFFF) ? SAT_MAX : 32'(quo_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AS_IDLE:
            begin
                if (start && op == OP_MUL) begin
                    state_next = AS_MUL;
                end
                else if (start && op == OP_DIV && !div_short) begin
                    state_next = AS_DIV;
                end
            end
            AS_MUL:  state_next = AS_IDLE;
            AS_DIV:  state_next = (cnt_reg == 6'd1) ? AS_FIN : AS_DIV;
            AS_FIN:  state_next = AS_IDLE;
            default: state_next = AS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                AS_IDLE:
                begin
                    if (start) begin
                        done_reg <= !(op == OP_MUL || (op == OP_DIV && !div_short));
                    end
                end
                AS_MUL:  done_reg <= 1'b1;
                AS_DIV:  done_reg <= 1'b0;
                AS_FIN:  done_reg <= 1'b1;
                default: done_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            AS_IDLE:
            begin
                if (start) begin
                    case (op)
                        OP_MUL: prod_reg <= a * b;
                        OP_ADD: res_reg <= sat32(64'(a) + 64'(b));
                        OP_SUB: res_reg <= sat32(64'(a) - 64'(b));
                        OP_DIV:
                        begin
                            res_reg <= div_quick;
                            neg_reg <= a[31] ^ b[31];
                            dvs_reg <= mag_b;
                            rem_reg <= num_w[63:32];
                            lo_reg  <= num_w[31:0];
                            quo_reg <= 32'd0;
                            cnt_reg <= 6'd32;
                        end
                        default: res_reg <= res_reg;
                    endcase
                end
            end
            AS_MUL: res_reg <= sat32(rnd);
            AS_DIV:
            begin
                rem_reg <= ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], ge};
                lo_reg  <= {lo_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
            end
            AS_FIN: res_reg <= div_fin;
            default: res_reg <= res_reg;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: src/cps_trig.sv
module cps_trig #(
    parameter int FRAC_BITS    = 24,
    parameter int CORDIC_ITERS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [31:0]   angle,
    output logic                 done,
    output logic signed [31:0]   sin_q,
    output logic signed [31:0]   cos_q
);
    import cps_pkg::*;

    localparam int SH   = 30 - FRAC_BITS;
    localparam int MW   = 64 - FRAC_BITS;
    localparam int MODN = 30 - FRAC_BITS;
    localparam int CW   = 34;
    localparam logic [MW-1:0] MOD_TOP = MW'(Q30_TWO_PI << (MODN - 1));
    localparam logic [5:0] ITER_LAST = 6'(CORDIC_ITERS - 1);

    trig_state_t state_reg, state_next;
    logic done_reg;
    logic [MW-1:0] mag_reg, modc_reg;
    logic neg_reg, flip_reg;
    logic [4:0] mcnt_reg;
    logic [5:0] icnt_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [31:0] sin_reg, cos_reg;

    logic signed [63:0] zw, zmag, zr, zh;
    logic signed [CW-1:0] xs, ys, at, xf, yf;

    always_comb
    begin
        zw   = {{32{angle[31]}}, angle} <<< SH;
        zmag = zw[63] ? -zw : zw;
        zr   = neg_reg ? -$signed({{FRAC_BITS{1'b0}}, mag_reg})
                       : $signed({{FRAC_BITS{1'b0}}, mag_reg});
        if (zr > Q30_PI) begin
            zr = zr - Q30_TWO_PI;
        end
        else if (zr < -Q30_PI) begin
            zr = zr + Q30_TWO_PI;
        end
        zh = 64'(z_reg);
        xs = x_reg >>> icnt_reg[4:0];
        ys = y_reg >>> icnt_reg[4:0];
        at = $signed({{(CW-32){1'b0}}, atan_q30(icnt_reg[4:0])});
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TS_IDLE: state_next = start ? TS_MOD : TS_IDLE;
            TS_MOD:  state_next = (mcnt_reg == 5'd1) ? TS_WRAP : TS_MOD;
            TS_WRAP: state_next = TS_HALF;
            TS_HALF: state_next = TS_ROT;
            TS_ROT:  state_next = (icnt_reg == ITER_LAST) ? TS_FIN : TS_ROT;
            TS_FIN:  state_next = TS_IDLE;
            default: state_next = TS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= TS_IDLE;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == TS_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            TS_IDLE:
            begin
                if (start) begin
                    mag_reg  <= zmag[MW-1:0];
                    neg_reg  <= zw[63];
                    modc_reg <= MOD_TOP;
                    mcnt_reg <= 5'(MODN);
                end
            end
            TS_MOD:
            begin
                // one remainder bit of the reduction by two pi
                if (mag_reg >= modc_reg) begin
                    mag_reg <= mag_reg - modc_reg;
                end
                modc_reg <= modc_reg >> 1;
                mcnt_reg <= mcnt_reg - 5'd1;
            end
            TS_WRAP: z_reg <= CW'(zr);
            TS_HALF:
            begin
                if (zh > Q30_HALF_PI) begin
                    z_reg    <= CW'(zh - Q30_PI);
                    flip_reg <= 1'b1;
                end
                else if (zh < -Q30_HALF_PI) begin
                    z_reg    <= CW'(zh + Q30_PI);
                    flip_reg <= 1'b1;
                end
                else begin
                    flip_reg <= 1'b0;
                end
                x_reg    <= CW'(Q30_GAIN);
                y_reg    <= '0;
                icnt_reg <= 6'd0;
            end
            TS_ROT:
            begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                icnt_reg <= icnt_reg + 6'd1;
            end
            TS_FIN:
            begin
                cos_reg <= sat32((64'(xf) + (64'sd1 <<< (SH - 1))) >>> SH);
                sin_reg <= sat32((64'(yf) + (64'sd1 <<< (SH - 1))) >>> SH);
            end
            default: mcnt_reg <= mcnt_reg;
        endcase
    end

    assign done  = done_reg;
    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

FILE: src/cart_pole_step_with_box.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | func, push_right
// out     | output    | out_valid / out_stall| cart_pos, cart_vel, pole_angle, pole_rate,
//         |           |                      | box_index, failed
// cfg     | input     | APB psel/penable     | paddr, pwdata, prdata
//
// A step beat runs from accept to the result register through the accept, sine and
// cosine by CORDIC, four divisions through the shared restoring divider (a saturated
// result straight from issue when one saturates or divides by zero), 15 multiplies,
// 8 adds and subtracts, the end step and the result load. A reset beat goes straight
// to the result load. Reset loads the register defaults and zeroes the state.
// in_stall stays high while a beat is in work; a result held by out_stall blocks
// only the next result, not the next accept.
module cart_pole_step_with_box #(
    parameter int FRAC_BITS    = 24,
    parameter int CORDIC_ITERS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic                push_right,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  cart_pos,
    output logic signed [31:0]  cart_vel,
    output logic signed [31:0]  pole_angle,
    output logic signed [31:0]  pole_rate,
    output logic [7:0]          box_index,
    output logic                failed,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import cps_pkg::*;

    // thresholds and the 4/3 factor, rounded to FRAC_BITS fraction bits
    localparam int CS = 32 - FRAC_BITS;
    localparam logic [63:0] RH = 64'd1 << (31 - FRAC_BITS);
    localparam logic [63:0] K43_W = (Q32_FOUR_THIRDS + RH) >> CS;
    localparam logic [63:0] XL_W  = (Q32_X_LIMIT + RH) >> CS;
    localparam logic [63:0] XE_W  = (Q32_X_EDGE + RH) >> CS;
    localparam logic [63:0] VE_W  = (Q32_V_EDGE + RH) >> CS;
    localparam logic [63:0] A12_W = (Q32_DEG12 + RH) >> CS;
    localparam logic [63:0] A6_W  = (Q32_DEG6 + RH) >> CS;
    localparam logic [63:0] A1_W  = (Q32_DEG1 + RH) >> CS;
    localparam logic [63:0] R50_W = (Q32_DEG50 + RH) >> CS;
    localparam logic signed [31:0] K43 = K43_W[31:0];
    localparam logic signed [31:0] XL  = XL_W[31:0];
    localparam logic signed [31:0] XE  = XE_W[31:0];
    localparam logic signed [31:0] VE  = VE_W[31:0];
    localparam logic signed [31:0] A12 = A12_W[31:0];
    localparam logic signed [31:0] A6  = A6_W[31:0];
    localparam logic signed [31:0] A1  = A1_W[31:0];
    localparam logic signed [31:0] R50 = R50_W[31:0];

    top_state_t state_reg, state_next;
    logic [4:0] pc_reg;

    // configuration
    logic [30:0] push_force_reg, tstep_reg, grav_reg, pmass_reg, tmass_reg, halfl_reg;

    // plant state and scratch values
    logic signed [31:0] pos_reg, vel_reg, ang_reg, rate_reg;
    logic signed [31:0] s_reg, c_reg, pml_reg, t1_reg, t2_reg, temp_reg;
    logic signed [31:0] den_reg, num_reg, tacc_reg, xacc_reg, force_reg;

    // result register
    logic out_valid_reg;
    logic signed [31:0] opos_reg, ovel_reg, oang_reg, orate_reg;
    logic [7:0] obox_reg;
    logic ofail_reg;

    uop_t uop;
    logic signed [31:0] opa, opb;
    logic alu_start, trig_start, alu_done, trig_done;
    logic signed [31:0] alu_res, trig_sin, trig_cos;
    logic accept, out_load, cfg_wr;
    logic fail;
    logic [7:0] box;

    assign uop    = uop_at(pc_reg);
    assign accept = in_valid && !in_stall;
    assign cfg_wr = psel && penable && pwrite;

    function automatic logic signed [31:0] pick(input src_t s,
        input logic signed [31:0] pm, hpl, tm, g, ts, frc, ps, vl, an, rt,
        input logic signed [31:0] sn, cs, pml, t1, t2, tmp, nm, dn, ta, xa);
        logic signed [31:0] r;
        unique case (s)
            SRC_PM:    r = pm;
            SRC_HPL:   r = hpl;
            SRC_TM:    r = tm;
            SRC_G:     r = g;
            SRC_TS:    r = ts;
            SRC_K43:   r = K43;
            SRC_FORCE: r = frc;
            SRC_POS:   r = ps;
            SRC_VEL:   r = vl;
            SRC_ANG:   r = an;
            SRC_RATE:  r = rt;
            SRC_S:     r = sn;
            SRC_C:     r = cs;
            SRC_PML:   r = pml;
            SRC_T1:    r = t1;
            SRC_T2:    r = t2;
            SRC_TEMP:  r = tmp;
            SRC_NUM:   r = nm;
            SRC_DEN:   r = dn;
            SRC_TACC:  r = ta;
            SRC_XACC:  r = xa;
            default:   r = 32'sd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        opa = pick(uop.a, {1'b0, pmass_reg}, {1'b0, halfl_reg}, {1'b0, tmass_reg},
                   {1'b0, grav_reg}, {1'b0, tstep_reg}, force_reg, pos_reg, vel_reg,
                   ang_reg, rate_reg, s_reg, c_reg, pml_reg, t1_reg, t2_reg,
                   temp_reg, num_reg, den_reg, tacc_reg, xacc_reg);
        opb = pick(uop.b, {1'b0, pmass_reg}, {1'b0, halfl_reg}, {1'b0, tmass_reg},
                   {1'b0, grav_reg}, {1'b0, tstep_reg}, force_reg, pos_reg, vel_reg,
                   ang_reg, rate_reg, s_reg, c_reg, pml_reg, t1_reg, t2_reg,
                   temp_reg, num_reg, den_reg, tacc_reg, xacc_reg);
    end

    cps_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start),
        .op    (uop.op),
        .a     (opa),
        .b     (opb),
        .done  (alu_done),
        .res   (alu_res)
    );

    cps_trig #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (ang_reg),
        .done  (trig_done),
        .sin_q (trig_sin),
        .cos_q (trig_cos)
    );

    // failure flag and 162-way box of the current state
    always_comb
    begin
        fail = pos_reg < -XL || pos_reg > XL || ang_reg < -A12 || ang_reg > A12;
        box = 8'd0;
        if (pos_reg >= XE) begin
            box = box + 8'd2;
        end
        else if (pos_reg >= -XE) begin
            box = box + 8'd1;
        end
        if (vel_reg >= VE) begin
            box = box + 8'd6;
        end
        else if (vel_reg >= -VE) begin
            box = box + 8'd3;
        end
        if (ang_reg >= A6) begin
            box = box + 8'd45;
        end
        else if (ang_reg >= A1) begin
            box = box + 8'd36;
        end
        else if (ang_reg >= 32'sd0) begin
            box = box + 8'd27;
        end
        else if (ang_reg >= -A1) begin
            box = box + 8'd18;
        end
        else if (ang_reg >= -A6) begin
            box = box + 8'd9;
        end
        if (rate_reg >= R50) begin
            box = box + 8'd108;
        end
        else if (rate_reg >= -R50) begin
            box = box + 8'd54;
        end
        if (fail) begin
            box = 8'd0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = func ? ST_OUT : ST_ISSUE;
                end
            end
            ST_ISSUE: state_next = (uop.op == OP_END) ? ST_OUT : ST_WAIT;
            ST_WAIT:  state_next = (alu_done || trig_done) ? ST_ISSUE : ST_WAIT;
            ST_OUT:   state_next = (!out_valid_reg || !out_stall) ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall   = 1'b1;
        alu_start  = 1'b0;
        trig_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_ISSUE:
            begin
                trig_start = (uop.op == OP_TRIG);
                alu_start  = (uop.op != OP_TRIG) && (uop.op != OP_END);
            end
            ST_WAIT:  in_stall = 1'b1;
            ST_OUT:   out_load = !out_valid_reg || !out_stall;
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            pc_reg         <= 5'd0;
            out_valid_reg  <= 1'b0;
            push_force_reg <= 31'd167772160;
            tstep_reg      <= 31'd335544;
            grav_reg       <= 31'd164416635;
            pmass_reg      <= 31'd1677722;
            tmass_reg      <= 31'd18454938;
            halfl_reg      <= 31'd8388608;
            pos_reg        <= 32'sd0;
            vel_reg        <= 32'sd0;
            ang_reg        <= 32'sd0;
            rate_reg       <= 32'sd0;
        end
        else begin
            state_reg <= state_next;

            // writes go straight in; the writer holds them off while a beat is in work
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_FORCE: push_force_reg <= pwdata[30:0];
                    REG_TSTEP: tstep_reg      <= pwdata[30:0];
                    REG_GRAV:  grav_reg       <= pwdata[30:0];
                    REG_PMASS: pmass_reg      <= pwdata[30:0];
                    REG_TMASS: tmass_reg      <= pwdata[30:0];
                    REG_HALFL: halfl_reg      <= pwdata[30:0];
                    default:   push_force_reg <= push_force_reg;
                endcase
            end

            if (accept) begin
                pc_reg <= 5'd0;
                if (func) begin
                    // reset beat: zero the plant, then report it from the output state
                    pos_reg  <= 32'sd0;
                    vel_reg  <= 32'sd0;
                    ang_reg  <= 32'sd0;
                    rate_reg <= 32'sd0;
                end
            end

            if (state_reg == ST_WAIT && (alu_done || trig_done)) begin
                pc_reg <= pc_reg + 5'd1;
                case (uop.dst)
                    DST_POS:  pos_reg  <= alu_res;
                    DST_VEL:  vel_reg  <= alu_res;
                    DST_ANG:  ang_reg  <= alu_res;
                    DST_RATE: rate_reg <= alu_res;
                    default:  pos_reg  <= pos_reg;
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scratch and result payload
    always_ff @(posedge clk)
    begin
        if (accept && !func) begin
            force_reg <= push_right ? $signed({1'b0, push_force_reg})
                                    : -$signed({1'b0, push_force_reg});
        end
        if (state_reg == ST_WAIT && trig_done) begin
            s_reg <= trig_sin;
            c_reg <= trig_cos;
        end
        if (state_reg == ST_WAIT && alu_done) begin
            case (uop.dst)
                DST_PML:  pml_reg  <= alu_res;
                DST_T1:   t1_reg   <= alu_res;
                DST_T2:   t2_reg   <= alu_res;
                DST_TEMP: temp_reg <= alu_res;
                DST_DEN:  den_reg  <= alu_res;
                DST_NUM:  num_reg  <= alu_res;
                DST_TACC: tacc_reg <= alu_res;
                DST_XACC: xacc_reg <= alu_res;
                default:  t1_reg   <= t1_reg;
            endcase
        end
        if (out_load) begin
            opos_reg  <= pos_reg;
            ovel_reg  <= vel_reg;
            oang_reg  <= ang_reg;
            orate_reg <= rate_reg;
            obox_reg  <= box;
            ofail_reg <= fail;
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_FORCE: prdata = {1'b0, push_force_reg};
            REG_TSTEP: prdata = {1'b0, tstep_reg};
            REG_GRAV:  prdata = {1'b0, grav_reg};
            REG_PMASS: prdata = {1'b0, pmass_reg};
            REG_TMASS: prdata = {1'b0, tmass_reg};
            REG_HALFL: prdata = {1'b0, halfl_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign pready     = 1'b1;
    assign out_valid  = out_valid_reg;
    assign cart_pos   = opos_reg;
    assign cart_vel   = ovel_reg;
    assign pole_angle = oang_reg;
    assign pole_rate  = orate_reg;
    assign box_index  = obox_reg;
    assign failed     = ofail_reg;

endmodule

FILE: tb/cart_pole_step_with_box_tb.sv
module cart_pole_step_with_box_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cps_pkg::*;

    // item kinds on the func field
    localparam logic FUNC_STEP  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;
    // an index past the last register: the write must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] ang;
        logic signed [31:0] rate;
        logic [7:0]         box;
        logic               fail;
    } plant_state_t;

    // Plant predictor plus the queue of predicted beats.
    class cart_pole_scoreboard;
        longint push_force, tstep, grav, pmass, tmass, half_len;
        longint pos, vel, ang, rate;
        plant_state_t predicted_q[$];
        int errors, n_steps, n_clears, n_failed, n_checked;
        longint atan_tab[24] = '{
            843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
            16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

        function void load_defaults();
            push_force = 167772160;
            tstep      = 335544;
            grav       = 164416635;
            pmass      = 1677722;
            tmass      = 18454938;
            half_len   = 8388608;
            pos = 0; vel = 0; ang = 0; rate = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            longint v;
            v = longint'(val & 32'h7FFF_FFFF);
            case (idx)
                REG_FORCE: push_force = v;
                REG_TSTEP: tstep = v;
                REG_GRAV:  grav = v;
                REG_PMASS: pmass = v;
                REG_TMASS: tmass = v;
                REG_HALFL: half_len = v;
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint q24(longint unsigned q32);
            return longint'((q32 + 64'd128) >> 8);
        endfunction

        function longint fmul(longint a, longint b);
            return clip((a * b + 64'sd8388608) >>> 24);
        endfunction

        function longint fdiv(longint a, longint b);
            if (b == 0) return a > 0 ? 64'sd2147483647 : (a < 0 ? -64'sd2147483648 : 0);
            return clip((a * 64'sd16777216) / b);
        endfunction

        function void sin_cos(longint a, output longint s, output longint c);
            longint z, x, y, nx;
            bit flip;
            z = a * 64;
            x = Q30_GAIN;
            y = 0;
            flip = 0;
            z = z % Q30_TWO_PI;
            if (z > Q30_PI) z -= Q30_TWO_PI;
            if (z < -Q30_PI) z += Q30_TWO_PI;
            if (z > Q30_HALF_PI) begin
                z -= Q30_PI;
                flip = 1;
            end
            else if (z < -Q30_HALF_PI) begin
                z += Q30_PI;
                flip = 1;
            end
            for (int i = 0; i < 24; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
                end
                else begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = clip((x + 32) >>> 6);
            s = clip((y + 32) >>> 6);
        endfunction

        function void note(logic f, logic p);
            longint s, c, pml, frc, temp, num, den, tacc, xacc, xl, a12;
            int b;
            plant_state_t r;
            if (f == FUNC_CLEAR) begin
                pos = 0; vel = 0; ang = 0; rate = 0;
                n_clears++;
            end
            else begin
                n_steps++;
                frc = p ? push_force : -push_force;
                sin_cos(ang, s, c);
                pml = fmul(pmass, half_len);
                temp = fdiv(clip(frc + fmul(fmul(pml, fmul(rate, rate)), s)), tmass);
                den = fmul(half_len,
                           clip(q24(Q32_FOUR_THIRDS) - fdiv(fmul(pmass, fmul(c, c)), tmass)));
                num = clip(fmul(grav, s) - fmul(c, temp));
                tacc = fdiv(num, den);
                xacc = clip(temp - fdiv(fmul(fmul(pml, tacc), c), tmass));
                // position and angle advance on the old rates
                pos  = clip(pos + fmul(tstep, vel));
                vel  = clip(vel + fmul(tstep, xacc));
                ang  = clip(ang + fmul(tstep, rate));
                rate = clip(rate + fmul(tstep, tacc));
            end
            xl  = q24(Q32_X_LIMIT);
            a12 = q24(Q32_DEG12);
            r.pos = pos[31:0]; r.vel = vel[31:0]; r.ang = ang[31:0]; r.rate = rate[31:0];
            r.fail = pos < -xl || pos > xl || ang < -a12 || ang > a12;
            if (r.fail) begin
                b = 0;
                n_failed++;
            end
            else begin
                b = pos < -q24(Q32_X_EDGE) ? 0 : (pos < q24(Q32_X_EDGE) ? 1 : 2);
                b += vel < -q24(Q32_V_EDGE) ? 0 : (vel < q24(Q32_V_EDGE) ? 3 : 6);
                if (ang < -q24(Q32_DEG6)) b += 0;
                else if (ang < -q24(Q32_DEG1)) b += 9;
                else if (ang < 0) b += 18;
                else if (ang < q24(Q32_DEG1)) b += 27;
                else if (ang < q24(Q32_DEG6)) b += 36;
                else b += 45;
                b += rate < -q24(Q32_DEG50) ? 0 : (rate < q24(Q32_DEG50) ? 54 : 108);
            end
            r.box = 8'(b);
            predicted_q.push_back(r);
        endfunction

        function void check(plant_state_t got);
            plant_state_t e;
            if (predicted_q.size() == 0) begin
                $error("result beat with nothing predicted");
                errors++;
                return;
            end
            e = predicted_q.pop_front();
            n_checked++;
            if (got.pos != e.pos) begin
                $error("cart_pos: expected %0d, got %0d", e.pos, got.pos); errors++;
            end
            if (got.vel != e.vel) begin
                $error("cart_vel: expected %0d, got %0d", e.vel, got.vel); errors++;
            end
            if (got.ang != e.ang) begin
                $error("pole_angle: expected %0d, got %0d", e.ang, got.ang); errors++;
            end
            if (got.rate != e.rate) begin
                $error("pole_rate: expected %0d, got %0d", e.rate, got.rate); errors++;
            end
            if (got.box != e.box) begin
                $error("box_index: expected %0d, got %0d", e.box, got.box); errors++;
            end
            if (got.fail != e.fail) begin
                $error("failed: expected %0d, got %0d", e.fail, got.fail); errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = FUNC_STEP;
    logic push_right = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] cart_pos, cart_vel, pole_angle, pole_rate;
    logic [7:0] box_index;
    logic failed;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cart_pole_step_with_box i_dut (.*);

    cart_pole_scoreboard plant = new();
    int burst_left = 0;
    int n_phases = 0;

    always #1 clk = ~clk;

    // Generous ceiling: a run that has not finished by then reports errors.
    initial
    begin
        #8_000_000;
        $display("cart_pole_step_with_box_tb: errors");
        $finish;
    end

    // Receiver: check every accepted result beat, then pick the next stall.
    // The stall mode drifts between none, light random and long holds.
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge clk)
    begin
        plant_state_t got;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got.pos = cart_pos; got.vel = cart_vel; got.ang = pole_angle;
                got.rate = pole_rate; got.box = box_index; got.fail = failed;
                plant.check(got);
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 400);
            end
            else begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // Hold one beat until it is taken, then either drop valid for a gap or
    // keep it high so the next beat of the burst follows at once.
    task automatic send_beat(logic f, logic p);
        int gap;
        in_valid <= 1'b1;
        func <= f;
        push_right <= p;
        do @(posedge clk); while (in_stall);
        plant.note(f, p);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end
        else begin
            burst_left = $urandom_range(0, 8);
            gap = $urandom_range(1, 20);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Make sure the last beat of a phase leaves valid low, then wait until every predicted beat is checked.
    task automatic quiesce();
        if (in_valid) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        burst_left = 0;
        while (plant.predicted_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, then access cycle, then idle; pready is always high.
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        plant.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_params(logic [31:0] fm, logic [31:0] ts, logic [31:0] g,
                               logic [31:0] pm, logic [31:0] tm, logic [31:0] hl);
        reg_write(REG_FORCE, fm);
        reg_write(REG_TSTEP, ts);
        reg_write(REG_GRAV, g);
        reg_write(REG_PMASS, pm);
        reg_write(REG_TMASS, tm);
        reg_write(REG_HALFL, hl);
        n_phases++;
    endtask

    // Well-formed episodes: clear, then a run of steps with random pushes,
    // with a stray clear now and then and runs past the failure point.
    task automatic run_episodes(int n);
        for (int k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(0, 29) == 0)
                send_beat(FUNC_CLEAR, 1'($urandom_range(0, 1)));
            else
                send_beat(FUNC_STEP, 1'($urandom_range(0, 1)));
        end
        quiesce();
    endtask

    function automatic logic [31:0] rnd_param(logic [31:0] nominal, bit nonzero);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 255);
            default: v = $urandom_range(0, nominal * 3);
        endcase
        if (nonzero && v[30:0] == 0) v = 32'd1;
        return v;
    endfunction

    initial
    begin
        plant.load_defaults();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset defaults: clear, pushes both ways, ride to failure,
        // step once more while failed, then clear back to the center box.
        send_beat(FUNC_CLEAR, 1'b1);
        repeat (3) send_beat(FUNC_STEP, 1'b1);
        repeat (3) send_beat(FUNC_STEP, 1'b0);
        repeat (14) send_beat(FUNC_STEP, 1'b1);
        send_beat(FUNC_STEP, 1'b0);
        send_beat(FUNC_CLEAR, 1'b0);
        quiesce();

        // Dropped and masked writes: an index past the table, and bit 31 masked off.
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        reg_write(REG_FORCE, 32'h8A00_0000);
        run_episodes(60);

        // Upper extremes: everything saturates, angle wraps far past pi.
        load_params(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_episodes(40);
        load_params(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'd1677722, 32'd1, 32'd8388608);
        run_episodes(60);

        // Lower extremes: zero force, step, gravity and pole mass, smallest divisors.
        load_params(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
        run_episodes(30);

        // Angular denominator driven to zero at small angles.
        load_params(32'd167772160, 32'd335544, 32'd164416635,
                    32'd22369621, 32'd16777216, 32'd1);
        run_episodes(40);

        // Random settings; mostly near nominal so episodes last a while.
        for (int ph = 0; ph < 10; ph++) begin
            load_params(rnd_param(32'd167772160, 0), rnd_param(32'd335544, 0),
                        rnd_param(32'd164416635, 0), rnd_param(32'd1677722, 0),
                        rnd_param(32'd18454938, 1), rnd_param(32'd8388608, 1));
            run_episodes(120);
        end

        // Back to the defaults for a long stretch.
        load_params(32'd167772160, 32'd335544, 32'd164416635,
                    32'd1677722, 32'd18454938, 32'd8388608);
        run_episodes(400);

        quiesce();
        repeat (20) @(posedge clk);
        $display("Covered %0d steps and %0d clears over %0d parameter sets.",
                 plant.n_steps, plant.n_clears, n_phases);
        $display("Checked %0d result beats, %0d of them in a failed state.",
                 plant.n_checked, plant.n_failed);
        if (plant.errors == 0 && plant.predicted_q.size() == 0)
            $display("cart_pole_step_with_box_tb: clean");
        else
            $display("cart_pole_step_with_box_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/cps_pkg.sv
src/cps_alu.sv
src/cps_trig.sv
src/cart_pole_step_with_box.sv
tb/cart_pole_step_with_box_tb.sv
